// File: rtl/core/tabsg_pkg.sv
// ----------------------------------------------------------------------------
// tabsg_pkg
// shared types and fixed field widths of the three-axis step generator
// ----------------------------------------------------------------------------
package tabsg_pkg;

  localparam int NumAxes  = 3;
  localparam int StepW    = 31;
  localparam int EventW   = 31;
  localparam int PosW     = 32;
  localparam int DirW     = NumAxes;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef logic [StepW-1:0]  step_cnt_t;
  typedef logic [EventW-1:0] event_cnt_t;
  typedef logic [PosW-1:0]   pos_t;
  typedef logic [DirW-1:0]   axis_bits_t;

endpackage

// File: rtl/core/three_axis_bresenham_step_generator.sv
// ----------------------------------------------------------------------------
// three_axis_bresenham_step_generator
// bresenham step generator for three axes, one output slot per request
// ----------------------------------------------------------------------------
// A request is either a segment load or a tick. Every request produces exactly
// one result, loaded into the result register on acceptance. One request is
// taken per clock unless stalled: the accumulate, compare and subtract of each
// axis, the slot counter and the position update all settle combinationally
// between segment state and result register. A result held back by out_stall_i
// stalls the input only while the result register is full and not being emptied.
module three_axis_bresenham_step_generator #(
  parameter int ACC_WIDTH      = 32,
  parameter int SEG_WIDTH      = 16,
  parameter int BLOCK_ID_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [BLOCK_ID_WIDTH-1:0]   block_id_i,
  input  tabsg_pkg::step_cnt_t        axis_steps_x_i,
  input  tabsg_pkg::step_cnt_t        axis_steps_y_i,
  input  tabsg_pkg::step_cnt_t        axis_steps_z_i,
  input  tabsg_pkg::event_cnt_t       event_count_i,
  input  tabsg_pkg::axis_bits_t       direction_in_i,
  input  logic [SEG_WIDTH-1:0]        segment_steps_i,
  input  logic [SEG_WIDTH-1:0]        slot_period_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tabsg_pkg::axis_bits_t       step_pulses_o,
  output tabsg_pkg::axis_bits_t       direction_out_o,
  output logic                        segment_done_o,
  output logic                        idle_o,
  output logic signed [tabsg_pkg::PosW-1:0] position_x_o,
  output logic signed [tabsg_pkg::PosW-1:0] position_y_o,
  output logic signed [tabsg_pkg::PosW-1:0] position_z_o
);
  import tabsg_pkg::*;

  localparam int CmpW = (ACC_WIDTH > EventW) ? ACC_WIDTH : EventW;

  // segment and block state
  logic [ACC_WIDTH-1:0]      acc_q [NumAxes];
  logic [ACC_WIDTH-1:0]      acc_d [NumAxes];
  step_cnt_t                 steps_q [NumAxes];
  step_cnt_t                 steps_d [NumAxes];
  pos_t                      pos_q [NumAxes];
  pos_t                      pos_d [NumAxes];
  logic [BLOCK_ID_WIDTH-1:0] last_block_q, last_block_d;
  event_cnt_t                events_q, events_d;
  axis_bits_t                dir_q, dir_d;
  logic [SEG_WIDTH-1:0]      steps_left_q, steps_left_d;
  logic [SEG_WIDTH-1:0]      period_q, period_d;
  logic [SEG_WIDTH-1:0]      slot_q, slot_d;
  logic                      active_q, active_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  axis_bits_t                pulses_q, pulses_d;
  axis_bits_t                dir_out_q, dir_out_d;
  logic                      done_q, done_d;
  logic                      idle_q, idle_d;
  pos_t                      pos_out_q [NumAxes];

  logic                      accept;
  logic [SEG_WIDTH-1:0]      slot_inc;
  logic                      step_slot;
  step_cnt_t                 steps_in [NumAxes];
  logic [ACC_WIDTH-1:0]      acc_next [NumAxes];
  logic                      hit [NumAxes];
  logic [CmpW-1:0]           events_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign steps_in[0] = axis_steps_x_i;
  assign steps_in[1] = axis_steps_y_i;
  assign steps_in[2] = axis_steps_z_i;

  assign events_ext = CmpW'(events_q);
  assign slot_inc   = slot_q + SEG_WIDTH'(1);
  // a period of zero behaves as one
  assign step_slot  = (slot_inc >= period_q);

  // per-axis bresenham update: add, compare against the event count, subtract
  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic [CmpW-1:0]      sum_ext;
    logic [ACC_WIDTH-1:0] sum;
    logic [CmpW-1:0]      diff_ext;

    assign sum_ext  = CmpW'(acc_q[a]) + CmpW'(steps_q[a]);
    assign sum      = sum_ext[ACC_WIDTH-1:0];
    assign hit[a]   = (CmpW'(sum) > events_ext);
    assign diff_ext = CmpW'(sum) - events_ext;
    assign acc_next[a] = hit[a] ? diff_ext[ACC_WIDTH-1:0] : sum;
  end

  always_comb begin
    acc_d        = acc_q;
    steps_d      = steps_q;
    pos_d        = pos_q;
    last_block_d = last_block_q;
    events_d     = events_q;
    dir_d        = dir_q;
    steps_left_d = steps_left_q;
    period_d     = period_q;
    slot_d       = slot_q;
    active_d     = active_q;
    pulses_d     = '0;
    dir_out_d    = '0;
    done_d       = 1'b0;
    idle_d       = 1'b0;

    if (accept) begin
      if (cmd_i == CMD_LOAD) begin
        steps_d      = steps_in;
        events_d     = event_count_i;
        dir_d        = direction_in_i;
        if (block_id_i != last_block_q) begin
          last_block_d = block_id_i;
          for (int a = 0; a < NumAxes; a++) begin
            acc_d[a] = ACC_WIDTH'(CmpW'(event_count_i >> 1));
          end
        end
        steps_left_d = segment_steps_i;
        period_d     = slot_period_i;
        slot_d       = '0;
        // empty segment finishes on the load itself
        active_d     = (segment_steps_i != '0);
        done_d       = (segment_steps_i == '0);
      end else if (!active_q) begin
        idle_d = 1'b1;
      end else if (step_slot) begin
        slot_d = '0;
        for (int a = 0; a < NumAxes; a++) begin
          acc_d[a]    = acc_next[a];
          pulses_d[a] = hit[a];
          if (hit[a]) begin
            pos_d[a] = dir_q[a] ? (pos_q[a] - PosW'(1)) : (pos_q[a] + PosW'(1));
          end
        end
        dir_out_d    = dir_q;
        steps_left_d = steps_left_q - SEG_WIDTH'(1);
        if (steps_left_q == SEG_WIDTH'(1)) begin
          active_d = 1'b0;
          done_d   = 1'b1;
        end
      end else begin
        slot_d = slot_inc;
      end
    end

    out_valid_d = accept || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        acc_q[a]   <= '0;
        steps_q[a] <= '0;
        pos_q[a]   <= '0;
      end
      last_block_q <= '0;
      events_q     <= '0;
      dir_q        <= '0;
      steps_left_q <= '0;
      period_q     <= '0;
      slot_q       <= '0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      steps_q      <= steps_d;
      pos_q        <= pos_d;
      last_block_q <= last_block_d;
      events_q     <= events_d;
      dir_q        <= dir_d;
      steps_left_q <= steps_left_d;
      period_q     <= period_d;
      slot_q       <= slot_d;
      active_q     <= active_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload, loaded on each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulses_q  <= pulses_d;
      dir_out_q <= dir_out_d;
      done_q    <= done_d;
      idle_q    <= idle_d;
      pos_out_q <= pos_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_pulses_o   = pulses_q;
  assign direction_out_o = dir_out_q;
  assign segment_done_o  = done_q;
  assign idle_o          = idle_q;
  assign position_x_o    = signed'(pos_out_q[0]);
  assign position_y_o    = signed'(pos_out_q[1]);
  assign position_z_o    = signed'(pos_out_q[2]);

`ifndef SYNTHESIS
  // a running segment always has step events left
  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (steps_left_q != '0))
    else $error("active segment with no steps left");

  // a segment ends only together with a done result
  a_fall_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (out_valid_o && segment_done_o))
    else $error("segment ended without done result");

  // a non-empty load starts a segment
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_LOAD) && (segment_steps_i != '0)) |=> active_q)
    else $error("load did not start segment");

  // a tick with nothing loaded reports idle
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_TICK) && !active_q) |=>
      (out_valid_o && idle_o && (step_pulses_o == '0) && !segment_done_o))
    else $error("idle tick result wrong");
`endif

endmodule

// File: test/three_axis_bresenham_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_bresenham_step_checker
// watches both channels of the step generator, predicts every slot and
// compares each accepted result with the oldest prediction still waiting
// ----------------------------------------------------------------------------
module three_axis_bresenham_step_checker #(
  parameter int AccWidth = 32,
  parameter int SegWidth = 16,
  parameter int BidWidth = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              cmd_i,
  input  logic [BidWidth-1:0]               block_id_i,
  input  tabsg_pkg::step_cnt_t              axis_steps_x_i,
  input  tabsg_pkg::step_cnt_t              axis_steps_y_i,
  input  tabsg_pkg::step_cnt_t              axis_steps_z_i,
  input  tabsg_pkg::event_cnt_t             event_count_i,
  input  tabsg_pkg::axis_bits_t             direction_in_i,
  input  logic [SegWidth-1:0]               segment_steps_i,
  input  logic [SegWidth-1:0]               slot_period_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  tabsg_pkg::axis_bits_t             step_pulses_i,
  input  tabsg_pkg::axis_bits_t             direction_out_i,
  input  logic                              segment_done_i,
  input  logic                              idle_i,
  input  logic signed [tabsg_pkg::PosW-1:0] position_x_i,
  input  logic signed [tabsg_pkg::PosW-1:0] position_y_i,
  input  logic signed [tabsg_pkg::PosW-1:0] position_z_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import tabsg_pkg::*;

  typedef struct packed {
    axis_bits_t pulses;
    axis_bits_t dir;
    logic       done;
    logic       idle;
    pos_t       pos_x;
    pos_t       pos_y;
    pos_t       pos_z;
  } slot_t;

  // generator state as the block should hold it
  logic [AccWidth-1:0] accum_q      [NumAxes];
  step_cnt_t           blk_steps_q  [NumAxes];
  pos_t                pos_q        [NumAxes];
  event_cnt_t          blk_events_q;
  logic [BidWidth-1:0] last_block_q;
  axis_bits_t          dir_held_q;
  logic [SegWidth-1:0] steps_left_q;
  logic [SegWidth-1:0] period_q;
  logic [SegWidth-1:0] slot_cnt_q;
  logic                running_q;

  slot_t expected_slots[$];
  int    results_seen;

  task automatic clear_generator();
    for (int a = 0; a < NumAxes; a++) begin
      accum_q[a]     = '0;
      blk_steps_q[a] = '0;
      pos_q[a]       = '0;
    end
    blk_events_q = '0;
    last_block_q = '0;
    dir_held_q   = '0;
    steps_left_q = '0;
    period_q     = '0;
    slot_cnt_q   = '0;
    running_q    = 1'b0;
  endtask

  task automatic run_generator_slot(output slot_t r);
    logic [AccWidth-1:0] sum;
    r = '0;
    if (cmd_e'(cmd_i) == CMD_LOAD) begin
      blk_steps_q[0] = axis_steps_x_i;
      blk_steps_q[1] = axis_steps_y_i;
      blk_steps_q[2] = axis_steps_z_i;
      blk_events_q   = event_count_i;
      dir_held_q     = direction_in_i;
      // a new block id restarts the bresenham error terms at half the events
      if (block_id_i != last_block_q) begin
        last_block_q = block_id_i;
        for (int a = 0; a < NumAxes; a++) accum_q[a] = AccWidth'(event_count_i >> 1);
      end
      steps_left_q = segment_steps_i;
      period_q     = slot_period_i;
      slot_cnt_q   = '0;
      if (segment_steps_i == '0) begin
        running_q = 1'b0;
        r.done    = 1'b1;
      end else begin
        running_q = 1'b1;
      end
    end else if (!running_q) begin
      r.idle = 1'b1;
    end else begin
      slot_cnt_q = slot_cnt_q + 1'b1;
      if (slot_cnt_q >= period_q) begin
        slot_cnt_q = '0;
        for (int a = 0; a < NumAxes; a++) begin
          sum = accum_q[a] + AccWidth'(blk_steps_q[a]);
          if (64'(sum) > 64'(blk_events_q)) begin
            sum         = sum - AccWidth'(blk_events_q);
            r.pulses[a] = 1'b1;
            pos_q[a]    = dir_held_q[a] ? pos_q[a] - 1'b1 : pos_q[a] + 1'b1;
          end
          accum_q[a] = sum;
        end
        r.dir        = dir_held_q;
        steps_left_q = steps_left_q - 1'b1;
        if (steps_left_q == '0) begin
          running_q = 1'b0;
          r.done    = 1'b1;
        end
      end
    end
    r.pos_x = pos_q[0];
    r.pos_y = pos_q[1];
    r.pos_z = pos_q[2];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    slot_t want;
    slot_t got;
    if (!rst_ni) begin
      clear_generator();
      expected_slots.delete();
      fail_count_o = 0;
      results_seen = 0;
    end else begin
      // predict first so a request and its result on one edge stay ordered
      if (in_valid_i && !in_stall_i) begin
        run_generator_slot(want);
        expected_slots.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{step_pulses_i, direction_out_i, segment_done_i, idle_i,
                position_x_i, position_y_i, position_z_i};
        if (expected_slots.size() == 0) begin
          if (fail_count_o < 10)
            $display("slot %0d: result with no request waiting, got %h", results_seen, got);
          fail_count_o++;
        end else begin
          want = expected_slots.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("slot %0d mismatch: exp pulses=%b dir=%b done=%b idle=%b pos=%h/%h/%h",
                       results_seen, want.pulses, want.dir, want.done, want.idle,
                       want.pos_x, want.pos_y, want.pos_z);
              $display("                 got pulses=%b dir=%b done=%b idle=%b pos=%h/%h/%h",
                       got.pulses, got.dir, got.done, got.idle,
                       got.pos_x, got.pos_y, got.pos_z);
            end
            fail_count_o++;
          end
        end
        results_seen++;
      end
    end
    pending_o = expected_slots.size();
  end

endmodule

// File: test/tb_three_axis_bresenham_step_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_axis_bresenham_step_generator
// drives segment loads and tick requests into the step generator with bursty
// input and a stalling receiver; a checker beside the block predicts and
// compares every slot, and this module gives the verdict
// ----------------------------------------------------------------------------
module tb_three_axis_bresenham_step_generator;
  import tabsg_pkg::*;

  localparam int AccWidth   = 32;
  localparam int SegWidth   = 16;
  localparam int BidWidth   = 8;
  localparam int NumItems   = 1700;
  localparam int StallLimit = 2000;

  localparam int StallNone   = 0;
  localparam int StallLight  = 1;
  localparam int StallHeavy  = 2;
  localparam int StallPeriod = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = CMD_TICK;
  logic [BidWidth-1:0]        block_id = '0;
  step_cnt_t                  axis_steps_x = '0;
  step_cnt_t                  axis_steps_y = '0;
  step_cnt_t                  axis_steps_z = '0;
  event_cnt_t                 event_count = '0;
  axis_bits_t                 direction_in = '0;
  logic [SegWidth-1:0]        segment_steps = '0;
  logic [SegWidth-1:0]        slot_period = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  axis_bits_t                 step_pulses;
  axis_bits_t                 direction_out;
  logic                       segment_done;
  logic                       idle;
  logic signed [PosW-1:0]     position_x;
  logic signed [PosW-1:0]     position_y;
  logic signed [PosW-1:0]     position_z;

  int fail_count;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = StallNone;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [BidWidth-1:0] last_bid = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  three_axis_bresenham_step_generator #(
    .ACC_WIDTH      (AccWidth),
    .SEG_WIDTH      (SegWidth),
    .BLOCK_ID_WIDTH (BidWidth)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .block_id_i      (block_id),
    .axis_steps_x_i  (axis_steps_x),
    .axis_steps_y_i  (axis_steps_y),
    .axis_steps_z_i  (axis_steps_z),
    .event_count_i   (event_count),
    .direction_in_i  (direction_in),
    .segment_steps_i (segment_steps),
    .slot_period_i   (slot_period),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .step_pulses_o   (step_pulses),
    .direction_out_o (direction_out),
    .segment_done_o  (segment_done),
    .idle_o          (idle),
    .position_x_o    (position_x),
    .position_y_o    (position_y),
    .position_z_o    (position_z)
  );

  three_axis_bresenham_step_checker #(
    .AccWidth (AccWidth),
    .SegWidth (SegWidth),
    .BidWidth (BidWidth)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .block_id_i      (block_id),
    .axis_steps_x_i  (axis_steps_x),
    .axis_steps_y_i  (axis_steps_y),
    .axis_steps_z_i  (axis_steps_z),
    .event_count_i   (event_count),
    .direction_in_i  (direction_in),
    .segment_steps_i (segment_steps),
    .slot_period_i   (slot_period),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .step_pulses_i   (step_pulses),
    .direction_out_i (direction_out),
    .segment_done_i  (segment_done),
    .idle_i          (idle),
    .position_x_i    (position_x),
    .position_y_i    (position_y),
    .position_z_i    (position_z),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // receiver back-pressure, switching between several patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(StallNone, StallPeriod);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 99) < 30);
      StallHeavy: out_stall <= ($urandom_range(0, 99) < 80);
      default:    out_stall <= (stall_left % 5 < 2);
    endcase
  end

  // ends the run when neither channel moves for too long
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(input cmd_e c, input logic [BidWidth-1:0] bid,
                              input step_cnt_t sx, input step_cnt_t sy,
                              input step_cnt_t sz, input event_cnt_t ev,
                              input axis_bits_t dir, input logic [SegWidth-1:0] segs,
                              input logic [SegWidth-1:0] per);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    cmd           <= c;
    block_id      <= bid;
    axis_steps_x  <= sx;
    axis_steps_y  <= sy;
    axis_steps_z  <= sz;
    event_count   <= ev;
    direction_in  <= dir;
    segment_steps <= segs;
    slot_period   <= per;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // a tick carries junk in the segment fields, the block must ignore it
  task automatic send_tick();
    send_request(CMD_TICK, BidWidth'($urandom), step_cnt_t'($urandom),
                 step_cnt_t'($urandom), step_cnt_t'($urandom), event_cnt_t'($urandom),
                 axis_bits_t'($urandom), SegWidth'($urandom), SegWidth'($urandom));
  endtask

  task automatic run_random_segment();
    logic [BidWidth-1:0] bid;
    event_cnt_t          ev;
    step_cnt_t           s [NumAxes];
    logic [SegWidth-1:0] segs;
    logic [SegWidth-1:0] per;
    longint              span;
    int                  ticks;
    int                  pick;

    pick = $urandom_range(0, 9);
    if (pick < 6)      bid = last_bid;
    else if (pick < 9) bid = BidWidth'($urandom_range(0, 3));
    else               bid = BidWidth'($urandom);

    if ($urandom_range(0, 9) < 8) begin
      // well-formed block: no axis moves more often than the event count
      ev = ($urandom_range(0, 3) == 0) ? event_cnt_t'($urandom)
                                       : event_cnt_t'($urandom_range(1, 60));
      for (int a = 0; a < NumAxes; a++) s[a] = step_cnt_t'($urandom_range(0, ev));
      s[$urandom_range(0, NumAxes - 1)] = ev;
    end else begin
      ev = $urandom_range(0, 1) ? event_cnt_t'($urandom)
                                : event_cnt_t'($urandom_range(0, 5));
      for (int a = 0; a < NumAxes; a++) s[a] = step_cnt_t'($urandom);
    end

    pick = $urandom_range(0, 19);
    if (pick == 0)     segs = '0;
    else if (pick < 3) segs = SegWidth'($urandom);
    else               segs = SegWidth'($urandom_range(1, 12));

    pick = $urandom_range(0, 19);
    if (pick < 2)       per = SegWidth'($urandom);
    else if (pick == 2) per = '0;
    else if (pick < 16) per = SegWidth'($urandom_range(1, 3));
    else                per = SegWidth'($urandom_range(4, 9));

    send_request(CMD_LOAD, bid, s[0], s[1], s[2], ev, axis_bits_t'($urandom), segs, per);
    last_bid = bid;

    span  = longint'(segs) * ((per == '0) ? 1 : longint'(per));
    ticks = (span > 60) ? 60 : int'(span);
    ticks += $urandom_range(0, 3);
    // sometimes cut the segment short so the next load lands while it runs
    if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
    repeat (ticks) send_tick();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with nothing loaded
    send_tick();
    // same id as after reset, empty segment finishes on the load
    send_request(CMD_LOAD, 8'd0, 31'd5, 31'd3, 31'd1, 31'd5, 3'b000, 16'd0, 16'd1);
    // widest event count, zero period steps every tick
    send_request(CMD_LOAD, 8'd5, 31'h7FFF_FFFF, 31'd0, 31'h3FFF_FFFF, 31'h7FFF_FFFF,
                 3'b101, 16'd3, 16'd0);
    repeat (3) send_tick();
    send_tick();
    // same id keeps the accumulators, oversized steps make them wrap
    send_request(CMD_LOAD, 8'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0,
                 3'b111, 16'd4, 16'd1);
    repeat (4) send_tick();
    // longest segment and period, then replaced while still running
    send_request(CMD_LOAD, 8'hFF, 31'd10, 31'd3, 31'd7, 31'd10, 3'b000,
                 16'hFFFF, 16'hFFFF);
    repeat (2) send_tick();
    send_request(CMD_LOAD, 8'hFF, 31'd4, 31'd10, 31'd9, 31'd10, 3'b010, 16'd2, 16'd2);
    repeat (4) send_tick();
    send_tick();
    last_bid = 8'hFF;

    while (items_sent < NumItems) run_random_segment();
    in_valid <= 1'b0;
    // let the checker record the last request before looking at its queue
    @(posedge clk);

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
